/* hw/rtl/lqs_pkg.sv */
package lqs_pkg;

  // field widths
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned ORD_W  = 11;

  // default number of slots
  localparam int unsigned DEPTH_DEFAULT = 8;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SRCH = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVF   = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // front/rear word reported for an empty queue
  localparam logic signed [WORD_W-1:0] NONE_WORD = -32'sd999;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [WORD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [WORD_W-1:0] data_out;
    logic [ORD_W-1:0]         match_order;
    logic [ORD_W-1:0]         fill_count;
    logic signed [WORD_W-1:0] head_word;
    logic signed [WORD_W-1:0] tail_word;
    logic                     is_empty;
    logic                     is_full;
  } out_item_t;

endpackage

/* hw/rtl/lqs_if.sv */
// command channel
interface lqs_in_if;
  logic              valid;
  logic              ready;
  lqs_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// result channel
interface lqs_out_if;
  logic               valid;
  logic               ready;
  lqs_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/linear_array_queue_with_search_top.sv */
// Linear (non-circular) array queue of DEPTH signed 32-bit words with enqueue, dequeue and
// search commands, one result per command. Words sit in a single-port-read, single-port-write
// RAM; slots freed by dequeues come back only once the queue drains, and enqueue reports
// overflow as soon as the rear reaches the last slot. The front and rear words are kept in
// registers so every result carries them without a RAM access. Enqueue passes through S_FIN,
// dequeue through S_FIN (through S_DEQ first when a new front word must be fetched), search
// through S_SCAN on a non-empty queue, comparing at most DEPTH entries, then S_FIN; the search
// scans the RAM read port one entry per cycle from the front. A command is taken while an
// earlier result still waits on the output register.
module linear_array_queue_with_search_top #(
  parameter int unsigned DEPTH = lqs_pkg::DEPTH_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  lqs_in_if.sink           in_i,
  lqs_out_if.source        out_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned WW   = lqs_pkg::WORD_W;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEQ  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]                state_q, state_d;
  logic [IdxW-1:0]           head_q, head_d;
  logic [CntW-1:0]           fill_q, fill_d;
  logic signed [WW-1:0]      head_word_q, head_word_d;
  logic signed [WW-1:0]      tail_word_q, tail_word_d;
  logic signed [WW-1:0]      key_q, key_d;
  logic [lqs_pkg::STAT_W-1:0] status_q, status_d;
  logic signed [WW-1:0]      data_q, data_d;
  logic [CntW-1:0]           order_q, order_d;
  logic [IdxW-1:0]           scan_q, scan_d;
  logic [CntW-1:0]           pos_q, pos_d;
  lqs_pkg::out_item_t        out_q, out_d;
  logic                      out_valid_q, out_valid_d;

  logic            wr_en, rd_en;
  logic [IdxW-1:0] wr_addr, rd_addr;
  logic [WW-1:0]   wr_data, rd_data;

  logic empty, full, in_fire, out_free;

  assign empty    = (fill_q == '0);
  assign full     = (fill_q == CntW'(DEPTH));
  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire  = in_i.valid & in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  lqs_ram #(
    .Depth (DEPTH),
    .AddrW (IdxW),
    .DataW (WW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // command sequencer
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    fill_d      = fill_q;
    head_word_d = head_word_q;
    tail_word_d = tail_word_q;
    key_d       = key_q;
    status_d    = status_q;
    data_d      = data_q;
    order_d     = order_q;
    scan_d      = scan_q;
    pos_d       = pos_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    wr_en       = 1'b0;
    wr_addr     = fill_q[IdxW-1:0];
    wr_data     = in_i.data.value;
    rd_en       = 1'b0;
    rd_addr     = head_q;

    // result taken downstream
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          status_d = lqs_pkg::ST_OK;
          data_d   = '0;
          order_d  = '0;
          state_d  = S_FIN;
          case (in_i.data.cmd)
            lqs_pkg::CMD_ENQ: begin
              if (full) begin
                status_d = lqs_pkg::ST_OVF;
              end else begin
                wr_en       = 1'b1;
                fill_d      = fill_q + CntW'(1);
                tail_word_d = in_i.data.value;
                if (empty) begin
                  head_word_d = in_i.data.value;
                end
              end
            end
            lqs_pkg::CMD_DEQ: begin
              if (empty) begin
                status_d = lqs_pkg::ST_EMPTY;
              end else begin
                data_d = head_word_q;
                if (CntW'(head_q) + CntW'(1) == fill_q) begin
                  // last word out, indices return to slot 0
                  head_d = '0;
                  fill_d = '0;
                end else begin
                  head_d  = head_q + IdxW'(1);
                  rd_en   = 1'b1;
                  rd_addr = head_q + IdxW'(1);
                  state_d = S_DEQ;
                end
              end
            end
            lqs_pkg::CMD_SRCH: begin
              key_d = in_i.data.value;
              if (!empty) begin
                rd_en   = 1'b1;
                rd_addr = head_q;
                scan_d  = head_q;
                pos_d   = CntW'(1);
                state_d = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DEQ: begin
        // new front word arrives from the ram
        head_word_d = rd_data;
        state_d     = S_FIN;
      end
      S_SCAN: begin
        if (rd_data == key_q) begin
          order_d = pos_q;
          state_d = S_FIN;
        end else if (CntW'(scan_q) + CntW'(1) == fill_q) begin
          state_d = S_FIN;
        end else begin
          rd_en   = 1'b1;
          rd_addr = scan_q + IdxW'(1);
          scan_d  = scan_q + IdxW'(1);
          pos_d   = pos_q + CntW'(1);
        end
      end
      S_FIN: begin
        // hand the result to the output register once it is free
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.status      = status_q;
          out_d.data_out    = data_q;
          out_d.match_order = lqs_pkg::ORD_W'(order_q);
          out_d.fill_count  = lqs_pkg::ORD_W'(fill_q - CntW'(head_q));
          out_d.head_word   = empty ? lqs_pkg::NONE_WORD : head_word_q;
          out_d.tail_word   = empty ? lqs_pkg::NONE_WORD : tail_word_q;
          out_d.is_empty    = empty;
          out_d.is_full     = full;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    head_word_q <= head_word_d;
    tail_word_q <= tail_word_d;
    key_q       <= key_d;
    status_q    <= status_d;
    data_q      <= data_d;
    order_q     <= order_d;
    scan_q      <= scan_d;
    pos_q       <= pos_d;
    out_q       <= out_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

/* hw/rtl/lqs_ram.sv */
module lqs_ram #(
  parameter int unsigned Depth = lqs_pkg::DEPTH_DEFAULT,
  parameter int unsigned AddrW = $clog2(Depth),
  parameter int unsigned DataW = lqs_pkg::WORD_W
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [DataW-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [DataW-1:0] rd_data_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rd_data_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hw/rtl/lqs_checker.sv */
module lqs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input lqs_pkg::out_item_t out_data_i
);

  // a stalled result holds still
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  // an empty queue reports no words and no count
  a_empty_view: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.is_empty |->
      out_data_i.fill_count == '0 && !out_data_i.is_full &&
      out_data_i.head_word == lqs_pkg::NONE_WORD &&
      out_data_i.tail_word == lqs_pkg::NONE_WORD)
    else $error("empty queue reports inconsistent view");

  // overflow only when the rear sits in the last slot
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status == lqs_pkg::ST_OVF |->
      out_data_i.is_full && out_data_i.data_out == '0 && out_data_i.match_order == '0)
    else $error("overflow reported on a queue that is not full");

  // a dequeued word comes only with ok status
  a_data_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.data_out != '0 |->
      out_data_i.status == lqs_pkg::ST_OK && out_data_i.match_order == '0)
    else $error("dequeued word with bad status or match");

  // a match lies within the held words
  a_match_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.match_order != '0 |->
      out_data_i.match_order <= out_data_i.fill_count &&
      out_data_i.status == lqs_pkg::ST_OK)
    else $error("match position beyond queue contents");

endmodule

bind linear_array_queue_with_search_top lqs_checker u_lqs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

/* tb/sv/linear_array_queue_with_search_top_tb.sv */
module linear_array_queue_with_search_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lqs_pkg::*;

  localparam int unsigned DEPTH = DEPTH_DEFAULT;
  // unused command code, the block treats it as a no-op
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  localparam logic signed [WORD_W-1:0] W_MAX = 32'sh7fff_ffff;
  localparam logic signed [WORD_W-1:0] W_MIN = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] W_A5  = 32'sh5555_5555;
  localparam logic signed [WORD_W-1:0] W_5A  = 32'shaaaa_aaaa;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 4 * DEPTH + 8;
  localparam int unsigned LONG_HOLD    = 80;
  localparam int unsigned PHASES       = 12;
  localparam int unsigned PHASE_ITEMS  = 48;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t res;
  } step_row_t;

  logic clk_i;
  logic rst_ni;

  lqs_in_if  cmd_if ();
  lqs_out_if res_if ();

  linear_array_queue_with_search_top #(
    .DEPTH(DEPTH)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_if),
    .out_o (res_if)
  );

  // shadow copy of the queue
  logic signed [WORD_W-1:0] slot_q [DEPTH];
  int unsigned head_idx;
  int unsigned tail_end;

  out_item_t   predicted_results [$];
  step_row_t   dir_tab [$];
  int unsigned mismatch_count;

  logic tx_idle_en;
  logic rx_idle_en;
  logic long_hold_req;

  out_item_t want;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // apply one command to the shadow queue and return the expected result
  function automatic out_item_t queue_step(input in_item_t it);
    out_item_t r;
    logic      empty;
    r = '0;
    r.status = ST_OK;
    case (it.cmd)
      CMD_ENQ: begin
        if (tail_end >= DEPTH) begin
          r.status = ST_OVF;
        end else begin
          slot_q[tail_end] = it.value;
          tail_end++;
        end
      end
      CMD_DEQ: begin
        if (tail_end == 0 || head_idx >= tail_end) begin
          r.status = ST_EMPTY;
        end else begin
          r.data_out = slot_q[head_idx];
          if (head_idx + 1 == tail_end) begin
            head_idx = 0;
            tail_end = 0;
          end else begin
            head_idx++;
          end
        end
      end
      CMD_SRCH: begin
        for (int unsigned i = head_idx; i < tail_end; i++) begin
          if (r.match_order == '0 && slot_q[i] == it.value) begin
            r.match_order = ORD_W'(i - head_idx + 1);
          end
        end
      end
      default: begin
      end
    endcase
    empty = (tail_end == 0 || head_idx >= tail_end);
    r.fill_count = empty ? '0 : ORD_W'(tail_end - head_idx);
    r.head_word  = empty ? NONE_WORD : slot_q[head_idx];
    r.tail_word  = empty ? NONE_WORD : slot_q[tail_end - 1];
    r.is_empty   = empty;
    r.is_full    = (tail_end == DEPTH);
    return r;
  endfunction

  function automatic out_item_t result_of(input logic [STAT_W-1:0] st,
                                          input logic signed [WORD_W-1:0] d,
                                          input logic [ORD_W-1:0] ord,
                                          input logic [ORD_W-1:0] cnt,
                                          input logic signed [WORD_W-1:0] hw,
                                          input logic signed [WORD_W-1:0] tw,
                                          input logic e, input logic f);
    out_item_t r;
    r.status      = st;
    r.data_out    = d;
    r.match_order = ord;
    r.fill_count  = cnt;
    r.head_word   = hw;
    r.tail_word   = tw;
    r.is_empty    = e;
    r.is_full     = f;
    return r;
  endfunction

  function automatic step_row_t row(input logic [CMD_W-1:0] c,
                                    input logic signed [WORD_W-1:0] v);
    step_row_t s;
    s = '0;
    s.item.cmd   = c;
    s.item.value = v;
    return s;
  endfunction

  function automatic step_row_t row_exp(input logic [CMD_W-1:0] c,
                                        input logic signed [WORD_W-1:0] v,
                                        input out_item_t r);
    step_row_t s;
    s = row(c, v);
    s.typed = 1'b1;
    s.res   = r;
    return s;
  endfunction

  // mostly small words so searches hit, with extremes and full-range noise
  function automatic logic signed [WORD_W-1:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      return WORD_W'($urandom_range(0, 7));
    end else if (r == 5) begin
      case ($urandom_range(0, 4))
        0: return W_MAX;
        1: return W_MIN;
        2: return -32'sd1;
        3: return NONE_WORD;
        default: return '0;
      endcase
    end
    return $urandom;
  endfunction

  // offer one command, wait for the transfer, record the expected result
  task automatic send_item(input in_item_t it, input logic use_typed,
                           input out_item_t typed_res);
    int        gap;
    out_item_t pred;
    gap = (tx_idle_en && $urandom_range(0, 5) == 0) ? int'($urandom_range(1, 11)) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= it;
    do @(posedge clk_i); while (!cmd_if.ready);
    pred = queue_step(it);
    predicted_results.push_back(use_typed ? typed_res : pred);
  endtask

  // result receiver with random stalls and one long hold
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(0, 10)) @(negedge clk_i);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (predicted_results.size() == 0) begin
        $error("result transfer with no expected result pending");
        mismatch_count++;
      end else begin
        want = predicted_results.pop_front();
        if (res_if.data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_if.data.status);
          mismatch_count++;
        end
        if (res_if.data.data_out !== want.data_out) begin
          $error("data_out: expected %0d, got %0d", want.data_out, res_if.data.data_out);
          mismatch_count++;
        end
        if (res_if.data.match_order !== want.match_order) begin
          $error("match_order: expected %0d, got %0d", want.match_order,
                 res_if.data.match_order);
          mismatch_count++;
        end
        if (res_if.data.fill_count !== want.fill_count) begin
          $error("fill_count: expected %0d, got %0d", want.fill_count,
                 res_if.data.fill_count);
          mismatch_count++;
        end
        if (res_if.data.head_word !== want.head_word) begin
          $error("head_word: expected %0d, got %0d", want.head_word, res_if.data.head_word);
          mismatch_count++;
        end
        if (res_if.data.tail_word !== want.tail_word) begin
          $error("tail_word: expected %0d, got %0d", want.tail_word, res_if.data.tail_word);
          mismatch_count++;
        end
        if (res_if.data.is_empty !== want.is_empty) begin
          $error("is_empty: expected %0d, got %0d", want.is_empty, res_if.data.is_empty);
          mismatch_count++;
        end
        if (res_if.data.is_full !== want.is_full) begin
          $error("is_full: expected %0d, got %0d", want.is_full, res_if.data.is_full);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("*** FAILED ***");
    $finish;
  end

  // stimulus
  initial begin
    in_item_t    it;
    int unsigned cnt;
    int unsigned r;
    logic        fill_mode;

    rst_ni         = 1'b0;
    cmd_if.valid   = 1'b0;
    cmd_if.data    = '0;
    tx_idle_en     = 1'b0;
    rx_idle_en     = 1'b1;
    long_hold_req  = 1'b0;
    mismatch_count = 0;
    head_idx       = 0;
    tail_end       = 0;
    fill_mode      = 1'b1;
    for (int i = 0; i < DEPTH; i++) slot_q[i] = '0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty queue, fill to the last slot, overflow, searches, drain
    dir_tab.push_back(row_exp(CMD_DEQ, '0,
      result_of(ST_EMPTY, '0, '0, '0, NONE_WORD, NONE_WORD, 1'b1, 1'b0)));
    dir_tab.push_back(row_exp(CMD_SRCH, -32'sd1,
      result_of(ST_OK, '0, '0, '0, NONE_WORD, NONE_WORD, 1'b1, 1'b0)));
    dir_tab.push_back(row_exp(CMD_NOP, W_MAX,
      result_of(ST_OK, '0, '0, '0, NONE_WORD, NONE_WORD, 1'b1, 1'b0)));
    dir_tab.push_back(row_exp(CMD_ENQ, W_MAX,
      result_of(ST_OK, '0, '0, 11'd1, W_MAX, W_MAX, 1'b0, 1'b0)));
    dir_tab.push_back(row_exp(CMD_ENQ, W_MIN,
      result_of(ST_OK, '0, '0, 11'd2, W_MAX, W_MIN, 1'b0, 1'b0)));
    dir_tab.push_back(row(CMD_ENQ, '0));
    dir_tab.push_back(row(CMD_ENQ, -32'sd1));
    dir_tab.push_back(row(CMD_ENQ, NONE_WORD));
    dir_tab.push_back(row(CMD_ENQ, -32'sd1));
    dir_tab.push_back(row(CMD_ENQ, W_A5));
    dir_tab.push_back(row(CMD_ENQ, W_5A));
    dir_tab.push_back(row_exp(CMD_ENQ, 32'sd5,
      result_of(ST_OVF, '0, '0, ORD_W'(DEPTH), W_MAX, W_5A, 1'b0, 1'b1)));
    dir_tab.push_back(row(CMD_SRCH, W_MAX));
    dir_tab.push_back(row(CMD_SRCH, W_5A));
    dir_tab.push_back(row(CMD_SRCH, -32'sd1));
    dir_tab.push_back(row(CMD_DEQ, '0));
    // slot freed at the head is not reused
    dir_tab.push_back(row(CMD_ENQ, 32'sd7));
    dir_tab.push_back(row(CMD_SRCH, -32'sd1));
    for (int i = 0; i < DEPTH - 1; i++) dir_tab.push_back(row(CMD_DEQ, $urandom));

    foreach (dir_tab[i]) send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].res);

    // random phases: fill and drain runs with random content
    for (int p = 0; p < PHASES; p++) begin
      tx_idle_en = (p < PHASES - 2) && (p % 3 != 2) && (p != 4);
      rx_idle_en = (p < PHASES - 2) && (p % 4 != 3);
      if (p == 4) long_hold_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        cnt = tail_end - head_idx;
        if (fill_mode && tail_end == DEPTH && $urandom_range(0, 3) == 0) fill_mode = 1'b0;
        if (!fill_mode && cnt == 0) fill_mode = 1'b1;
        r = $urandom_range(0, 99);
        if (r < (fill_mode ? 55 : 15)) begin
          it.cmd = CMD_ENQ;
        end else if (r < (fill_mode ? 75 : 65)) begin
          it.cmd = CMD_DEQ;
        end else if (r < 95) begin
          it.cmd = CMD_SRCH;
        end else begin
          it.cmd = CMD_NOP;
        end
        if (it.cmd == CMD_SRCH && cnt > 0 && $urandom_range(0, 2) != 0) begin
          it.value = slot_q[head_idx + $urandom_range(0, cnt - 1)];
        end else if (it.cmd == CMD_ENQ || it.cmd == CMD_SRCH) begin
          it.value = pick_word();
        end else begin
          it.value = $urandom;
        end
        send_item(it, 1'b0, '0);
      end
      // sender pauses until everything has come back
      if (p == 2 || p == 6 || p == 9) begin
        @(negedge clk_i);
        cmd_if.valid <= 1'b0;
        wait (predicted_results.size() == 0);
      end
    end

    @(negedge clk_i);
    cmd_if.valid <= 1'b0;
    wait (predicted_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
